// ----- hdl/tfd_pkg.sv -----
// Package for the telemetry field decoder: field widths, mode and register
// codes, the day-divide constants and the structs passed between modules.
// No dependencies.
`default_nettype none

package tfd_pkg;

  // Width of the raw input field and of the decoded result.
  localparam int RAW_W = 32;
  localparam int VAL_W = 33;

  // Number of valid bits in a raw word; bits at and above it read as zero.
  localparam int WORD_WIDTH = 32;
  localparam logic [RAW_W-1:0] WORD_MASK = RAW_W'((64'd1 << WORD_WIDTH) - 64'd1);

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_W      = 6;

  // Register indexes, taken from paddr[3:2].
  typedef enum logic [1:0] {
    REG_MODE      = 2'd0,
    REG_FIELD_TOP = 2'd1,
    REG_FIELD_LEN = 2'd2,
    REG_WORD_BITS = 2'd3
  } tfd_reg_e;

  // Decode modes. Code 7 is unused and behaves like pass-through.
  typedef enum logic [2:0] {
    MODE_SFIELD = 3'd0,
    MODE_UFIELD = 3'd1,
    MODE_SWORD  = 3'd2,
    MODE_UWORD  = 3'd3,
    MODE_DAYS   = 3'd4,
    MODE_SOD    = 3'd5,
    MODE_PASS   = 3'd6
  } tfd_mode_e;

  // Seconds per day is 675 * 2^7. The quotient is estimated as
  // ((w >> 7) * floor(2^35 / 675)) >> 35, which is low by at most one.
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;
  localparam int          DAY_SHIFT    = 7;
  localparam int          RECIP_SHIFT  = 35;
  localparam int          QUOT_W       = 16;
  localparam int          REM_W        = 18;
  localparam int          DAY_X_W      = RAW_W - DAY_SHIFT;
  localparam int          RECIP_W      = 26;
  localparam logic [RECIP_W-1:0] DAY_RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd675);
  localparam int          PROD_W       = DAY_X_W + RECIP_W;

  // What the second stage does with an item.
  typedef enum logic [1:0] {
    RES_DIRECT = 2'd0,
    RES_DAYS   = 2'd1,
    RES_SOD    = 2'd2
  } tfd_kind_e;

  typedef struct packed {
    logic [2:0]       mode;
    logic [CFG_W-1:0] field_top;
    logic [CFG_W-1:0] field_len;
    logic [CFG_W-1:0] word_bits;
  } tfd_cfg_t;

  typedef struct packed {
    tfd_kind_e         kind;
    logic [VAL_W-1:0]  direct;
    logic [RAW_W-1:0]  word;
    logic [QUOT_W-1:0] quot_est;
  } tfd_mid_t;

endpackage

`default_nettype wire

// ----- hdl/tfd_if.sv -----
// Valid/ready channel interfaces for the raw-word input and the decoded output.
// Depends on tfd_pkg.
`default_nettype none

interface tfd_in_if import tfd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_word;

  modport source (output valid, output raw_word, input ready);
  modport sink   (input valid, input raw_word, output ready);
endinterface

interface tfd_out_if import tfd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] decoded_value;

  modport source (output valid, output decoded_value, input ready);
  modport sink   (input valid, input decoded_value, output ready);
endinterface

`default_nettype wire

// ----- hdl/tfd_cfg_regs.sv -----
// APB-style configuration registers of the telemetry field decoder.
// Depends on tfd_pkg.
`default_nettype none

module tfd_cfg_regs import tfd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output tfd_cfg_t                   cfg
);

  tfd_cfg_t cfg_r;
  tfd_cfg_t cfg_nxt;
  logic     wr_en;
  tfd_reg_e reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = tfd_reg_e'(paddr[3:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:      cfg_nxt.mode      = pwdata[2:0];
        REG_FIELD_TOP: cfg_nxt.field_top = pwdata[CFG_W-1:0];
        REG_FIELD_LEN: cfg_nxt.field_len = pwdata[CFG_W-1:0];
        REG_WORD_BITS: cfg_nxt.word_bits = pwdata[CFG_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_PASS;
      cfg_r.field_top <= CFG_W'(0);
      cfg_r.field_len <= CFG_W'(1);
      cfg_r.word_bits <= CFG_W'(32);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_MODE:      prdata = CFG_DATA_W'(cfg_r.mode);
      REG_FIELD_TOP: prdata = CFG_DATA_W'(cfg_r.field_top);
      REG_FIELD_LEN: prdata = CFG_DATA_W'(cfg_r.field_len);
      REG_WORD_BITS: prdata = CFG_DATA_W'(cfg_r.word_bits);
      default:       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- hdl/tfd_extract.sv -----
// First decode stage: field and word extraction with sign extension, and the
// reciprocal-multiply estimate of the day count. Depends on tfd_pkg.
`default_nettype none

module tfd_extract import tfd_pkg::*; (
  input  wire tfd_cfg_t          cfg,
  input  wire logic [RAW_W-1:0]  raw_word,
  output tfd_mid_t               mid
);

  logic [RAW_W-1:0]   word;
  logic               word_mode;
  logic               signed_mode;
  logic [CFG_W-1:0]   len_cfg;
  logic [CFG_W-1:0]   len;
  logic [7:0]         diff;
  logic [CFG_W-1:0]   lo;
  logic [RAW_W-1:0]   shifted;
  logic [VAL_W-1:0]   mask;
  logic [VAL_W-1:0]   field;
  logic               sign_bit;
  logic [VAL_W-1:0]   extracted;
  logic [PROD_W-1:0]  prod;

  assign word = raw_word & WORD_MASK;

  assign word_mode   = (cfg.mode == MODE_SWORD) || (cfg.mode == MODE_UWORD);
  assign signed_mode = (cfg.mode == MODE_SFIELD) || (cfg.mode == MODE_SWORD);
  assign len_cfg     = word_mode ? cfg.word_bits : cfg.field_len;
  assign len         = (len_cfg == '0) ? CFG_W'(1) : len_cfg;

  // Low bit of the field is top + 1 - len. When the top index sits too low it
  // is raised in whole bytes, which leaves the low bit at (top + 1 - len) mod 8.
  assign diff = {2'b00, cfg.field_top} + 8'd1 - {2'b00, len};
  assign lo   = word_mode ? '0 : (diff[7] ? {3'b000, diff[2:0]} : diff[CFG_W-1:0]);

  assign shifted  = word >> lo;
  assign mask     = ~({VAL_W{1'b1}} << len);
  assign field    = {1'b0, shifted} & mask;
  // The field's top bit; zero for lengths past the result width.
  assign sign_bit = |(field & (mask ^ (mask >> 1)));

  assign extracted = (signed_mode && sign_bit) ? (field | ~mask) : field;

  assign prod = PROD_W'(word[RAW_W-1:DAY_SHIFT]) * PROD_W'(DAY_RECIP);

  always_comb begin
    mid.word     = word;
    mid.quot_est = prod[RECIP_SHIFT +: QUOT_W];
    mid.direct   = {1'b0, word};
    mid.kind     = RES_DIRECT;
    unique case (cfg.mode)
      MODE_SFIELD, MODE_UFIELD, MODE_SWORD, MODE_UWORD: mid.direct = extracted;
      MODE_DAYS:   mid.kind = RES_DAYS;
      MODE_SOD:    mid.kind = RES_SOD;
      MODE_PASS:   mid.direct = {1'b0, word};
      default:     mid.direct = {1'b0, word};
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/tfd_day_fix.sv -----
// Second decode stage: corrects the day-count estimate by one remainder check
// and picks the final value. Depends on tfd_pkg.
`default_nettype none

module tfd_day_fix import tfd_pkg::*; (
  input  wire tfd_mid_t           mid,
  output logic signed [VAL_W-1:0] value
);

  logic [RAW_W+1:0]  day_secs;
  logic [REM_W-1:0]  rem;
  logic              over;
  logic [QUOT_W-1:0] days;
  logic [REM_W-1:0]  sod;

  assign day_secs = (RAW_W+2)'(mid.quot_est) * (RAW_W+2)'(SECS_PER_DAY);
  // The true remainder stays below two days, so the low bits are enough.
  assign rem  = mid.word[REM_W-1:0] - day_secs[REM_W-1:0];
  assign over = rem >= REM_W'(SECS_PER_DAY);
  assign days = mid.quot_est + QUOT_W'(over);
  assign sod  = over ? (rem - REM_W'(SECS_PER_DAY)) : rem;

  always_comb begin
    unique case (mid.kind)
      RES_DAYS: value = VAL_W'(days);
      RES_SOD:  value = VAL_W'(sod);
      default:  value = mid.direct;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/telemetry_field_decoder.sv -----
// Top level of the telemetry field decoder: configuration registers and a
// two-register decode pipeline. Depends on tfd_pkg, tfd_if, tfd_cfg_regs,
// tfd_extract and tfd_day_fix.
//
//   Port group   Direction  Handshake          Payload
//   in_item      sink       valid / ready      raw_word (32 bits)
//   out_item     source     valid / ready      decoded_value (33 bits, signed)
//   APB          slave      psel/penable/pready paddr[3:0], pwdata, prdata
//
// Every item passes two register stages, mid_r and then out_val_r; one item can
// be accepted per cycle while the output is not held. The depth is set by the
// day-count reciprocal multiply, which is registered before its correction.
// The pipeline stalls only while the output is held; a held output still lets
// one more item into the middle stage. Reset clears the valid flags and loads
// the register defaults.
`default_nettype none

module telemetry_field_decoder import tfd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  tfd_in_if.sink                     in_item,
  tfd_out_if.source                  out_item,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready
);

  tfd_cfg_t                cfg;
  tfd_mid_t                mid;
  tfd_mid_t                mid_r;
  logic                    mid_v_r;
  logic                    mid_v_nxt;
  logic signed [VAL_W-1:0] value;
  logic signed [VAL_W-1:0] out_val_r;
  logic                    out_v_r;
  logic                    out_v_nxt;
  logic                    advance;
  logic                    in_ready;

  tfd_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfd_extract u_extract (
    .cfg      (cfg),
    .raw_word (in_item.raw_word),
    .mid      (mid)
  );

  tfd_day_fix u_day_fix (
    .mid   (mid_r),
    .value (value)
  );

  assign advance  = !out_v_r || out_item.ready;
  assign in_ready = !mid_v_r || advance;

  assign mid_v_nxt = in_ready ? in_item.valid : mid_v_r;
  assign out_v_nxt = advance ? mid_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      mid_v_r <= mid_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_item.valid) begin
      mid_r <= mid;
    end
    if (advance && mid_v_r) begin
      out_val_r <= value;
    end
  end

  assign in_item.ready          = in_ready;
  assign out_item.valid         = out_v_r;
  assign out_item.decoded_value = out_val_r;

endmodule

`default_nettype wire

// ----- test/telemetry_field_decoder_test.sv -----
// Self-checking testbench for telemetry_field_decoder: drives raw words under many register
// settings, predicts each decoded value and compares it with the block's output stream.
// Depends on tfd_pkg, tfd_if and the decoder RTL.
`timescale 1ns / 1ps

module telemetry_field_decoder_test;
  import tfd_pkg::*;

  localparam time         CLK_PERIOD  = 4ns;
  localparam int          STALL_LIMIT = 1000;
  localparam int          PHASES      = 24;
  localparam logic [63:0] DAY_SECONDS = 64'd86400;
  localparam logic [2:0]  MODE_UNUSED = 3'd7;
  localparam tfd_cfg_t    CFG_AT_RESET = '{MODE_PASS, 6'd0, 6'd1, 6'd32};

  logic clk = 1'b0;
  logic rst_n;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  tfd_in_if  in_ch ();
  tfd_out_if out_ch ();

  telemetry_field_decoder i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Words waiting to be sent, and decoded values waiting to come out.
  logic [RAW_W-1:0]        raw_q[$];
  logic signed [VAL_W-1:0] decoded_q[$];

  tfd_cfg_t                cfg_shadow = CFG_AT_RESET;
  bit                      idle_on;
  int                      src_gap;
  int                      snk_gap;
  int                      stall_cycles;
  int                      error_count;
  logic signed [VAL_W-1:0] expected_val;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic logic signed [VAL_W-1:0] decode_raw(logic [RAW_W-1:0] raw, tfd_cfg_t c);
    logic [63:0] w;
    logic [63:0] fld;
    int unsigned len;
    int unsigned top;
    logic        sgn;
    w   = 64'(raw & WORD_MASK);
    len = 1;
    top = 0;
    sgn = 1'b0;
    case (c.mode)
      MODE_SFIELD, MODE_UFIELD: begin
        len = (c.field_len == 0) ? 1 : c.field_len;
        top = c.field_top;
        // A top index too low for the length moves up a byte at a time.
        while (top + 1 < len) top += 8;
        sgn = (c.mode == MODE_SFIELD);
      end
      MODE_SWORD, MODE_UWORD: begin
        len = (c.word_bits == 0) ? 1 : c.word_bits;
        top = len - 1;
        sgn = (c.mode == MODE_SWORD);
      end
      MODE_DAYS: return VAL_W'(w / DAY_SECONDS);
      MODE_SOD:  return VAL_W'(w % DAY_SECONDS);
      default:   return VAL_W'(w);
    endcase
    // Shifts past the word width give zero, so bits above the word read as zero.
    fld = (w >> (top + 1 - len)) & ((64'd1 << len) - 64'd1);
    if (sgn && top < 64) begin
      if (w[top]) fld = fld - (64'd1 << len);
    end
    return fld[VAL_W-1:0];
  endfunction

  task automatic add_word(input logic [RAW_W-1:0] w);
    raw_q = {raw_q, w};
  endtask

  task automatic apb_write(input tfd_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE:      cfg_shadow.mode      = data[2:0];
      REG_FIELD_TOP: cfg_shadow.field_top = data[CFG_W-1:0];
      REG_FIELD_LEN: cfg_shadow.field_len = data[CFG_W-1:0];
      REG_WORD_BITS: cfg_shadow.word_bits = data[CFG_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apply_reg(input tfd_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    apb_write(idx, data);
  endtask

  // With noise set, the unused upper bits of each write carry random values.
  task automatic load_cfg(input tfd_cfg_t c, input bit noise);
    logic [CFG_DATA_W-1:0] junk;
    junk = noise ? CFG_DATA_W'($urandom()) : '0;
    apply_reg(REG_MODE, (junk & ~32'h7) | 32'(c.mode));
    junk = noise ? CFG_DATA_W'($urandom()) : '0;
    apply_reg(REG_FIELD_TOP, (junk & ~32'h3F) | 32'(c.field_top));
    junk = noise ? CFG_DATA_W'($urandom()) : '0;
    apply_reg(REG_FIELD_LEN, (junk & ~32'h3F) | 32'(c.field_len));
    junk = noise ? CFG_DATA_W'($urandom()) : '0;
    apply_reg(REG_WORD_BITS, (junk & ~32'h3F) | 32'(c.word_bits));
  endtask

  // Every word yields one value, so an empty expectation queue means the pipe is empty.
  // The check runs on the falling edge, once the drivers' updates have settled.
  task automatic wait_idle();
    do @(negedge clk); while (raw_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
  endtask

  // Input side: present words from raw_q and predict each one as it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.raw_word <= '0;
      src_gap        <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decoded_q = {decoded_q, decode_raw(in_ch.raw_word, cfg_shadow)};
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (src_gap != 0) begin
          in_ch.valid <= 1'b0;
          src_gap     <= src_gap - 1;
        end else if (raw_q.size() != 0) begin
          in_ch.valid    <= 1'b1;
          in_ch.raw_word <= raw_q.pop_front();
          if (idle_on && $urandom_range(0, 7) == 0) src_gap <= $urandom_range(1, 6);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output side: random back-pressure and the comparison against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      snk_gap      <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          $error("decoded_value: expected nothing, got %0d", out_ch.decoded_value);
          error_count++;
        end else begin
          expected_val = decoded_q.pop_front();
          if (out_ch.decoded_value !== expected_val) begin
            $error("decoded_value: expected %0d, got %0d", expected_val, out_ch.decoded_value);
            error_count++;
          end
        end
      end
      if (snk_gap != 0) begin
        out_ch.ready <= 1'b0;
        snk_gap      <= snk_gap - 1;
      end else begin
        out_ch.ready <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) snk_gap <= $urandom_range(1, 6);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[telemetry_field_decoder] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    tfd_cfg_t         c;
    int               n;
    logic [RAW_W-1:0] word;
    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.raw_word = '0;
    out_ch.ready   = 1'b0;
    idle_on        = 1'b1;
    error_count    = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Settings after reset: pass-through.
    add_word(32'h0000_0000);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    // Signed field over the whole word.
    load_cfg('{MODE_SFIELD, 6'd31, 6'd32, 6'd32}, 1'b0);
    add_word(32'h8000_0000);
    add_word(32'h7FFF_FFFF);
    wait_idle();

    // A field lying wholly above the word reads as zero, sign included.
    load_cfg('{MODE_SFIELD, 6'd63, 6'd16, 6'd32}, 1'b0);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    // A zero length counts as one bit.
    load_cfg('{MODE_SFIELD, 6'd2, 6'd0, 6'd32}, 1'b0);
    add_word(32'h0000_0004);
    add_word(32'h0000_0000);
    wait_idle();

    // Length beyond 32: the top index climbs past the word and zeros fill in.
    load_cfg('{MODE_UFIELD, 6'd3, 6'd40, 6'd32}, 1'b0);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    // The top index climbs from bit 0 to bit 8.
    load_cfg('{MODE_UFIELD, 6'd0, 6'd8, 6'd32}, 1'b0);
    add_word(32'hFFFF_FFA5);
    wait_idle();

    load_cfg('{MODE_SWORD, 6'd0, 6'd1, 6'd32}, 1'b0);
    add_word(32'h8000_0000);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    load_cfg('{MODE_SWORD, 6'd0, 6'd1, 6'd0}, 1'b0);
    add_word(32'h0000_0001);
    add_word(32'h0000_0000);
    wait_idle();

    load_cfg('{MODE_UWORD, 6'd0, 6'd1, 6'd63}, 1'b0);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    load_cfg('{MODE_UWORD, 6'd0, 6'd1, 6'd1}, 1'b0);
    add_word(32'hFFFF_FFFE);
    wait_idle();

    load_cfg('{MODE_DAYS, 6'd0, 6'd1, 6'd32}, 1'b0);
    add_word(32'd0);
    add_word(32'd86399);
    add_word(32'd86400);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    load_cfg('{MODE_SOD, 6'd0, 6'd1, 6'd32}, 1'b0);
    add_word(32'd0);
    add_word(32'd86399);
    add_word(32'd86400);
    add_word(32'hFFFF_FFFF);
    wait_idle();

    // The unused mode code behaves as pass-through.
    load_cfg('{MODE_UNUSED, 6'd0, 6'd1, 6'd32}, 1'b0);
    add_word(32'hDEAD_BEEF);
    wait_idle();

    // Random settings, each with a batch of random words; the last batch runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      c.mode      = 3'($urandom_range(0, 7));
      c.field_top = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(0, 31));
      c.field_len = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 32));
      c.word_bits = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                                : 6'($urandom_range(1, 32));
      load_cfg(c, 1'b1);
      idle_on = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 64);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 5))
          0: word = RAW_W'($urandom_range(0, 255));
          1: word = ~RAW_W'($urandom_range(0, 255));
          2: word = RAW_W'(DAY_SECONDS * $urandom_range(0, 49710)) +
                    RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
          3: word = RAW_W'(1) << $urandom_range(0, 31);
          default: word = RAW_W'($urandom());
        endcase
        add_word(word);
      end
      wait_idle();
    end

    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("[telemetry_field_decoder] OK");
    end else begin
      $display("[telemetry_field_decoder] ERROR");
    end
    $finish;
  end

endmodule
